### hdl/serial_bank_switch_mapper_unit_defines.svh
// Assertion macros for the serial bank switch mapper.
`ifndef SERIAL_BANK_SWITCH_MAPPER_UNIT_DEFINES_SVH
`define SERIAL_BANK_SWITCH_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbsm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBSM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbsm: next-cycle check failed");

`endif

### hdl/sbsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbsm_pkg;

    localparam logic [4:0] CtrlPowerOn   = 5'h0C;
    localparam logic [4:0] PrgRomReset   = 5'd2;
    localparam logic [4:0] ChrRomReset   = 5'd1;

    // Register targets selected by address bits 14:13
    localparam logic [1:0] SelControl = 2'd0;
    localparam logic [1:0] SelChrLow  = 2'd1;
    localparam logic [1:0] SelChrHigh = 2'd2;
    localparam logic [1:0] SelPrg     = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CfgPrgRomPages = 2'd0;
    localparam logic [1:0] CfgChrRomPages = 2'd1;
    localparam logic [1:0] CfgMirroring   = 2'd2;

    // Cartridge mirroring codes
    localparam logic [1:0] CartMirrorVert = 2'd1;
    localparam logic [1:0] CartMirrorHorz = 2'd2;

    // Operations
    localparam logic OpWrite = 1'b0;
    localparam logic OpReset = 1'b1;

    typedef struct packed {
        logic [4:0] prg_rom_pages;
        logic [4:0] chr_rom_pages;
        logic [1:0] power_on_mirroring;
    } sbsm_cfg_t;

    typedef struct packed {
        logic [3:0] prg_page_low;
        logic [3:0] prg_page_high;
        logic [4:0] chr_bank_low;
        logic [4:0] chr_bank_high;
        logic       prg_ram_enable;
        logic [1:0] mirroring_mode;
        logic       register_committed;
    } sbsm_result_t;

    // Drop high bank bits, top first, while the bank is at or above the limit.
    function automatic logic [4:0] clamp_bank(input logic [4:0] bank,
                                              input logic [5:0] limit);
        logic [4:0] b;
        b = bank;
        for (int i = 4; i >= 0; i--)
        begin
            if ({1'b0, b} >= limit)
            begin
                b[i] = 1'b0;
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

### hdl/serial_bank_switch_mapper_unit.sv
// Serial bank switch mapper.
// Input channel (in_valid / in_stall) carries one CPU write to the ROM window
// per beat: op, cpu_address and write_data. Output channel (out_valid /
// out_stall) returns one beat per input beat with the decoded memory map
// (PRG pages, CHR banks, work RAM enable, mirroring) and a flag that marks the
// write that completed a five-bit register load.
// The map decode of an accepted beat is registered in the output buffer.
// Throughput is one beat per cycle while in_stall is low; the serial shifter and bank registers are
// updated in the accept cycle and the map decode feeds the output register.
// A two-entry output buffer parts the channels: while the receiver stalls one
// further beat is taken into the skid entry, then in_stall rises until the
// receiver takes a beat.
// The configuration port (cfg_write, cfg_index, cfg_data) writes the page
// counts and cartridge mirroring; write it only while no beat is in flight.
// Reset clears the shifter, loads control with 0x0C, zeroes the bank
// registers, restores the configuration defaults and empties the output.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_bank_switch_mapper_unit_defines.svh"

module serial_bank_switch_mapper_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [15:0] cpu_address,
    input  wire logic [7:0]  write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       prg_page_low,
    output logic [3:0]       prg_page_high,
    output logic [4:0]       chr_bank_low,
    output logic [4:0]       chr_bank_high,
    output logic             prg_ram_enable,
    output logic [1:0]       mirroring_mode,
    output logic             register_committed
);
    import sbsm_pkg::*;

    sbsm_cfg_t    cfg_reg;
    sbsm_result_t core_result;
    sbsm_result_t out_data;
    logic         accept;
    logic         buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_rom_pages      <= PrgRomReset;
            cfg_reg.chr_rom_pages      <= ChrRomReset;
            cfg_reg.power_on_mirroring <= 2'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CfgPrgRomPages: cfg_reg.prg_rom_pages      <= cfg_data;
                CfgChrRomPages: cfg_reg.chr_rom_pages      <= cfg_data;
                CfgMirroring:   cfg_reg.power_on_mirroring <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    sbsm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op),
        .reg_sel    (cpu_address[14:13]),
        .write_data (write_data),
        .cfg        (cfg_reg),
        .result     (core_result)
    );

    sbsm_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign prg_page_low       = out_data.prg_page_low;
    assign prg_page_high      = out_data.prg_page_high;
    assign chr_bank_low       = out_data.chr_bank_low;
    assign chr_bank_high      = out_data.chr_bank_high;
    assign prg_ram_enable     = out_data.prg_ram_enable;
    assign mirroring_mode     = out_data.mirroring_mode;
    assign register_committed = out_data.register_committed;

    `SBSM_ASSERT_IMP(a_skid_needs_out, clk, rst_n, buf_full, out_valid)
    `SBSM_ASSERT_IMP(a_skid_fill_on_stall, clk, rst_n, $rose(buf_full),
        $past(out_valid && out_stall && accept))
    `SBSM_ASSERT_NXT(a_skid_drains, clk, rst_n, buf_full && !out_stall,
        out_valid && !buf_full)

endmodule

`default_nettype wire

### hdl/sbsm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sbsm_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic                  op,
    input  wire logic [1:0]            reg_sel,
    input  wire logic [7:0]            write_data,
    input  wire sbsm_pkg::sbsm_cfg_t   cfg,
    output sbsm_pkg::sbsm_result_t     result
);
    import sbsm_pkg::*;

    logic [4:0] shift_reg, shift_next;
    logic [2:0] count_reg, count_next;
    logic [4:0] control_reg, control_next;
    logic [4:0] chr_low_reg, chr_low_next;
    logic [4:0] chr_high_reg, chr_high_next;
    logic [4:0] prg_reg, prg_next;
    logic       committed;

    logic [4:0] shifted;
    logic [1:0] mirror_bits;
    logic [3:0] bank;
    logic [4:0] c0, c1;
    logic [5:0] chr_limit;
    logic       ram_en;

    always_comb
    begin
        shift_next    = shift_reg;
        count_next    = count_reg;
        control_next  = control_reg;
        chr_low_next  = chr_low_reg;
        chr_high_next = chr_high_reg;
        prg_next      = prg_reg;
        committed     = 1'b0;
        shifted       = {write_data[0], shift_reg[4:1]};

        case (cfg.power_on_mirroring)
            CartMirrorVert: mirror_bits = 2'b10;
            CartMirrorHorz: mirror_bits = 2'b11;
            default:        mirror_bits = 2'b00;
        endcase

        if (op == OpReset)
        begin
            control_next  = CtrlPowerOn | {3'b000, mirror_bits};
            chr_low_next  = '0;
            chr_high_next = '0;
            prg_next      = '0;
            shift_next    = '0;
            count_next    = '0;
        end
        else if (write_data[7])
        begin
            shift_next = '0;
            count_next = '0;
        end
        else if (count_reg >= 3'd4)
        begin
            // fifth bit: load the target register and restart the shifter
            case (reg_sel)
                SelControl: control_next  = shifted;
                SelChrLow:  chr_low_next  = shifted;
                SelChrHigh: chr_high_next = shifted;
                SelPrg:     prg_next      = shifted;
                default:    prg_next      = shifted;
            endcase
            committed  = 1'b1;
            shift_next = '0;
            count_next = '0;
        end
        else
        begin
            shift_next = shifted;
            count_next = count_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= '0;
            count_reg    <= '0;
            control_reg  <= CtrlPowerOn;
            chr_low_reg  <= '0;
            chr_high_reg <= '0;
            prg_reg      <= '0;
        end
        else if (accept)
        begin
            shift_reg    <= shift_next;
            count_reg    <= count_next;
            control_reg  <= control_next;
            chr_low_reg  <= chr_low_next;
            chr_high_reg <= chr_high_next;
            prg_reg      <= prg_next;
        end
    end

    // Decode the map from the updated register set.
    always_comb
    begin
        bank      = prg_next[3:0];
        ram_en    = ~prg_next[4];
        chr_limit = {cfg.chr_rom_pages, 1'b0};
        c0        = chr_low_next;
        c1        = chr_high_next;

        if (!control_next[4])
        begin
            c0 = {chr_low_next[4:1], 1'b0};
            c1 = {chr_low_next[4:1], 1'b1};
        end

        if (cfg.chr_rom_pages == 5'd0)
        begin
            if (!(c0[4] | c1[4]))
            begin
                ram_en = 1'b0;
            end
            c0[4] = 1'b0;
            c1[4] = 1'b0;
        end
        else
        begin
            c0 = clamp_bank(c0, chr_limit);
            c1 = clamp_bank(c1, chr_limit);
        end

        result.chr_bank_low       = c0;
        result.chr_bank_high      = c1;
        result.prg_ram_enable     = ram_en;
        result.mirroring_mode     = control_next[1:0];
        result.register_committed = committed;

        case (control_next[3:2])
            2'd2:
            begin
                result.prg_page_low  = 4'd0;
                result.prg_page_high = bank;
            end
            2'd3:
            begin
                result.prg_page_low  = bank;
                result.prg_page_high = cfg.prg_rom_pages[3:0] - 4'd1;
            end
            default:
            begin
                result.prg_page_low  = {bank[3:1], 1'b0};
                result.prg_page_high = {bank[3:1], 1'b1};
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/sbsm_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module sbsm_outbuf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire sbsm_pkg::sbsm_result_t load_data,
    output logic                       full,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output sbsm_pkg::sbsm_result_t     out_data
);
    import sbsm_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    sbsm_result_t out_data_reg, out_data_next;
    sbsm_result_t skid_data_reg, skid_data_next;
    logic         out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // drain the skid beat first; no load is taken while it is full
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = load_data;
                out_valid_next = load;
            end
        end
        else if (load)
        begin
            // output stalled: park the new beat
            skid_data_next  = load_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### tb/serial_bank_switch_mapper_unit_tb.sv
`timescale 1ns / 1ps

module serial_bank_switch_mapper_unit_tb;
    import sbsm_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int PhaseItems = 171;
    localparam int NumRows    = 25;

    // Index with no register behind it
    localparam logic [1:0] CfgSpare = 2'd3;

    // PRG modes taken from control bits 3:2; lower modes switch 32 KB
    localparam logic [1:0] PrgModeFixFirst = 2'd2;
    localparam logic [1:0] PrgModeFixLast  = 2'd3;

    // Mirroring as reported in control bits 1:0
    localparam logic [1:0] MirrorVertical   = 2'd2;
    localparam logic [1:0] MirrorHorizontal = 2'd3;

    typedef struct packed {
        logic         op;
        logic [15:0]  addr;
        logic [7:0]   data;
        logic         fixed;
        sbsm_result_t want;
    } stim_row_t;

    localparam sbsm_result_t PowerOnMap = '{
        prg_page_low: 4'd0, prg_page_high: 4'd1,
        chr_bank_low: 5'd0, chr_bank_high: 5'd1,
        prg_ram_enable: 1'b1, mirroring_mode: 2'd0, register_committed: 1'b0
    };

    localparam stim_row_t DirectedRows [NumRows] = '{
        '{OpWrite, 16'h8000, 8'h80, 1'b1, PowerOnMap},
        // control <- 0x1F
        '{OpWrite, 16'h9FFF, 8'h7F, 1'b0, '0},
        '{OpWrite, 16'h9FFF, 8'h7F, 1'b0, '0},
        '{OpWrite, 16'h9FFF, 8'h7F, 1'b0, '0},
        '{OpWrite, 16'h9FFF, 8'h7F, 1'b0, '0},
        '{OpWrite, 16'h9FFF, 8'h7F, 1'b0, '0},
        // PRG bank <- 0x1F, work RAM off
        '{OpWrite, 16'hE000, 8'h01, 1'b0, '0},
        '{OpWrite, 16'hE000, 8'h7F, 1'b0, '0},
        '{OpWrite, 16'hE000, 8'h55, 1'b0, '0},
        '{OpWrite, 16'hE000, 8'h33, 1'b0, '0},
        '{OpWrite, 16'hE000, 8'h0F, 1'b0, '0},
        // partial load broken by a shifter reset byte
        '{OpWrite, 16'hA000, 8'h00, 1'b0, '0},
        '{OpWrite, 16'hA000, 8'h01, 1'b0, '0},
        '{OpWrite, 16'hA000, 8'hFE, 1'b0, '0},
        // CHR low <- 29, clamped against the page count
        '{OpWrite, 16'hBFFF, 8'h01, 1'b0, '0},
        '{OpWrite, 16'hBFFF, 8'h00, 1'b0, '0},
        '{OpWrite, 16'hBFFF, 8'h2B, 1'b0, '0},
        '{OpWrite, 16'hBFFF, 8'h11, 1'b0, '0},
        '{OpWrite, 16'hBFFF, 8'h7F, 1'b0, '0},
        // CHR high <- 0
        '{OpWrite, 16'hC000, 8'h00, 1'b0, '0},
        '{OpWrite, 16'hC000, 8'h7E, 1'b0, '0},
        '{OpWrite, 16'hC000, 8'h40, 1'b0, '0},
        '{OpWrite, 16'hC000, 8'h02, 1'b0, '0},
        '{OpWrite, 16'hC000, 8'h00, 1'b0, '0},
        '{OpReset, 16'hFFFF, 8'hFF, 1'b1, PowerOnMap}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  prg_page_low;
    logic [3:0]  prg_page_high;
    logic [4:0]  chr_bank_low;
    logic [4:0]  chr_bank_high;
    logic        prg_ram_enable;
    logic [1:0]  mirroring_mode;
    logic        register_committed;

    // Mapper state as the predictor sees it
    logic [4:0] shift_q;
    logic [2:0] shift_cnt;
    logic [4:0] ctrl_q;
    logic [4:0] chr_lo_q;
    logic [4:0] chr_hi_q;
    logic [4:0] prg_q;
    logic [4:0] prg_pages;
    logic [4:0] chr_pages;
    logic [1:0] cart_mirror;

    sbsm_result_t map_expected_q [$];
    sbsm_result_t head_map;
    int mismatch_count = 0;
    int cycle_count = 0;
    int burst_left = 0;

    serial_bank_switch_mapper_unit i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .op                 (op),
        .cpu_address        (cpu_address),
        .write_data         (write_data),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .prg_page_low       (prg_page_low),
        .prg_page_high      (prg_page_high),
        .chr_bank_low       (chr_bank_low),
        .chr_bank_high      (chr_bank_high),
        .prg_ram_enable     (prg_ram_enable),
        .mirroring_mode     (mirroring_mode),
        .register_committed (register_committed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void power_on_regs();
        ctrl_q = CtrlPowerOn;
        if (cart_mirror == CartMirrorVert)
        begin
            ctrl_q[1:0] = MirrorVertical;
        end
        else if (cart_mirror == CartMirrorHorz)
        begin
            ctrl_q[1:0] = MirrorHorizontal;
        end
        chr_lo_q  = 5'd0;
        chr_hi_q  = 5'd0;
        prg_q     = 5'd0;
        shift_q   = 5'd0;
        shift_cnt = 3'd0;
    endfunction

    // Strip high bits, bit 4 first, while the bank is still out of range
    function automatic logic [4:0] trim_chr_bank(logic [4:0] bank, logic [5:0] limit);
        logic [4:0] b;
        int         i;
        b = bank;
        i = 4;
        while (i >= 0 && {1'b0, b} >= limit)
        begin
            b[i] = 1'b0;
            i--;
        end
        return b;
    endfunction

    function automatic sbsm_result_t map_step(logic o, logic [15:0] a, logic [7:0] d);
        sbsm_result_t r;
        logic [4:0]   c0;
        logic [4:0]   c1;
        logic [4:0]   last;
        r = '0;
        if (o == OpReset)
        begin
            power_on_regs();
        end
        else if (d[7])
        begin
            shift_q   = 5'd0;
            shift_cnt = 3'd0;
        end
        else
        begin
            shift_q   = {d[0], shift_q[4:1]};
            shift_cnt = shift_cnt + 3'd1;
            if (shift_cnt == 3'd5)
            begin
                case (a[14:13])
                    SelControl: ctrl_q   = shift_q;
                    SelChrLow:  chr_lo_q = shift_q;
                    SelChrHigh: chr_hi_q = shift_q;
                    default:    prg_q    = shift_q;
                endcase
                r.register_committed = 1'b1;
                shift_q   = 5'd0;
                shift_cnt = 3'd0;
            end
        end

        c0 = chr_lo_q;
        c1 = chr_hi_q;
        r.prg_ram_enable = ~prg_q[4];
        if (!ctrl_q[4])
        begin
            c0[0] = 1'b0;
            c1    = {c0[4:1], 1'b1};
        end
        if (chr_pages == 5'd0)
        begin
            // CHR RAM: bit 4 of either bank keeps work RAM alive
            if (!(c0[4] | c1[4]))
            begin
                r.prg_ram_enable = 1'b0;
            end
            c0[4] = 1'b0;
            c1[4] = 1'b0;
        end
        else
        begin
            c0 = trim_chr_bank(c0, {chr_pages, 1'b0});
            c1 = trim_chr_bank(c1, {chr_pages, 1'b0});
        end

        last = prg_pages - 5'd1;
        case (ctrl_q[3:2])
            PrgModeFixFirst:
            begin
                r.prg_page_low  = 4'd0;
                r.prg_page_high = prg_q[3:0];
            end
            PrgModeFixLast:
            begin
                r.prg_page_low  = prg_q[3:0];
                r.prg_page_high = last[3:0];
            end
            default:
            begin
                r.prg_page_low  = {prg_q[3:1], 1'b0};
                r.prg_page_high = {prg_q[3:1], 1'b1};
            end
        endcase
        r.chr_bank_low   = c0;
        r.chr_bank_high  = c1;
        r.mirroring_mode = ctrl_q[1:0];
        return r;
    endfunction

    function automatic logic [15:0] rand_addr(logic [1:0] target);
        logic [15:0] a;
        a = 16'($urandom);
        a[14:13] = target;
        // mostly inside the ROM window, now and then below it
        if ($urandom_range(0, 15) != 0)
        begin
            a[15] = 1'b1;
        end
        return a;
    endfunction

    task automatic send_write(logic o, logic [15:0] a, logic [7:0] d, logic fixed,
                              sbsm_result_t want);
        sbsm_result_t predicted;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(30, 60);
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
            end
        end
        in_valid    = 1'b1;
        op          = o;
        cpu_address = a;
        write_data  = d;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = map_step(o, a, d);
        map_expected_q.push_back(fixed ? want : predicted);
        burst_left--;
    endtask

    task automatic run_random(int n_items);
        int         sent;
        int         kind;
        int         cut;
        logic [1:0] target;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 78)
            begin
                // full five-bit load, any beat occasionally aimed at a random register
                target = 2'($urandom_range(0, 3));
                for (int k = 0; k < 5; k++)
                begin
                    send_write(OpWrite,
                               rand_addr(($urandom_range(0, 3) == 0) ?
                                         2'($urandom_range(0, 3)) : target),
                               {1'b0, 7'($urandom)}, 1'b0, '0);
                end
                sent += 5;
            end
            else if (kind < 90)
            begin
                cut = $urandom_range(1, 4);
                for (int k = 0; k < cut; k++)
                begin
                    send_write(OpWrite, rand_addr(2'($urandom_range(0, 3))),
                               {1'b0, 7'($urandom)}, 1'b0, '0);
                end
                send_write(OpWrite, rand_addr(2'($urandom_range(0, 3))),
                           8'($urandom) | 8'h80, 1'b0, '0);
                sent += cut + 1;
            end
            else if (kind < 95)
            begin
                send_write(OpReset, 16'($urandom), 8'($urandom), 1'b0, '0);
                sent++;
            end
            else
            begin
                send_write(OpWrite, 16'($urandom), 8'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Hold the input side quiet until every result is back, then let the pipe drain
    task automatic settle();
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        while (map_expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CfgPrgRomPages: prg_pages   = val;
            CfgChrRomPages: chr_pages   = val;
            CfgMirroring:   cart_mirror = val[1:0];
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (map_expected_q.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                mismatch_count++;
            end
            else
            begin
                head_map = map_expected_q.pop_front();
                check_field("prg_page_low", 8'(head_map.prg_page_low), 8'(prg_page_low));
                check_field("prg_page_high", 8'(head_map.prg_page_high), 8'(prg_page_high));
                check_field("chr_bank_low", 8'(head_map.chr_bank_low), 8'(chr_bank_low));
                check_field("chr_bank_high", 8'(head_map.chr_bank_high), 8'(chr_bank_high));
                check_field("prg_ram_enable", 8'(head_map.prg_ram_enable),
                            8'(prg_ram_enable));
                check_field("mirroring_mode", 8'(head_map.mirroring_mode),
                            8'(mirroring_mode));
                check_field("register_committed", 8'(head_map.register_committed),
                            8'(register_committed));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("serial_bank_switch_mapper_unit regression: fail");
            $finish;
        end
    end

    // Receiver: short stalls between free runs, with the odd long free stretch
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                out_stall = 1'b0;
                repeat ($urandom_range(30, 60)) @(negedge clk);
            end
            out_stall = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            out_stall = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    end

    initial
    begin
        logic [4:0] prg_set;
        logic [4:0] chr_set;
        logic [1:0] mir_set;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = CfgPrgRomPages;
        cfg_data    = 5'd0;
        in_valid    = 1'b0;
        op          = OpWrite;
        cpu_address = 16'h8000;
        write_data  = 8'h00;
        prg_pages   = PrgRomReset;
        chr_pages   = ChrRomReset;
        cart_mirror = 2'd0;
        power_on_regs();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NumRows; i++)
        begin
            send_write(DirectedRows[i].op, DirectedRows[i].addr, DirectedRows[i].data,
                       DirectedRows[i].fixed, DirectedRows[i].want);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    prg_set = 5'd1;
                    chr_set = 5'd0;
                    mir_set = 2'd1;
                end
                1:
                begin
                    prg_set = 5'd16;
                    chr_set = 5'd16;
                    mir_set = 2'd2;
                end
                2:
                begin
                    prg_set = 5'd0;
                    chr_set = 5'd31;
                    mir_set = 2'd3;
                end
                3:
                begin
                    prg_set = 5'd31;
                    chr_set = 5'd1;
                    mir_set = 2'd0;
                end
                4:
                begin
                    prg_set = 5'($urandom_range(1, 16));
                    chr_set = 5'($urandom_range(0, 16));
                    mir_set = 2'($urandom_range(0, 2));
                end
                default:
                begin
                    prg_set = 5'($urandom);
                    chr_set = 5'($urandom);
                    mir_set = 2'($urandom);
                end
            endcase
            write_reg(CfgPrgRomPages, prg_set);
            write_reg(CfgChrRomPages, chr_set);
            // upper data bits are don't-care for the mirroring register
            write_reg(CfgMirroring, {3'($urandom), mir_set});
            if (ph == 2)
            begin
                write_reg(CfgSpare, 5'h1F);
            end
            run_random(PhaseItems);
        end

        settle();
        if (mismatch_count == 0)
        begin
            $display("serial_bank_switch_mapper_unit regression: pass");
        end
        else
        begin
            $display("serial_bank_switch_mapper_unit regression: fail");
        end
        $finish;
    end

endmodule
